// ===== src/e2q_pkg.sv =====
// ============================================================================
// e2q_pkg
// Shared constants for the Euler angle to quaternion pipeline: parameter
// defaults, Q2.30 angle constants and the CORDIC arctangent table.
// ============================================================================
package e2q_pkg;

    localparam int ANGLE_BITS_DEF     = 16;
    localparam int COMPONENT_BITS_DEF = 16;

    // internal CORDIC word: Q2.30 with headroom
    localparam int FRAC_INT     = 30;
    localparam int CORDIC_ITERS = 30;
    localparam int CW           = 34;

    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

    // atan(2^-i) in Q30
    localparam logic [31:0] ATAN_TAB [0:CORDIC_ITERS-1] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,
        32'd64,        32'd32,        32'd16,        32'd8,
        32'd4,         32'd2
    };

endpackage

// ===== src/e2q_cordic.sv =====
// ============================================================================
// e2q_cordic
// One angle lane: halves and folds the angle, runs a fully pipelined
// rotation-mode CORDIC and rounds sine and cosine of the half angle to Q1.F.
// ============================================================================
module e2q_cordic #(
    parameter int ANGLE_BITS     = e2q_pkg::ANGLE_BITS_DEF,
    parameter int COMPONENT_BITS = e2q_pkg::COMPONENT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             ce,
    input  logic                             in_valid,
    input  logic signed [ANGLE_BITS-1:0]     angle,
    output logic                             out_valid,
    output logic signed [COMPONENT_BITS-1:0] sin_out,
    output logic signed [COMPONENT_BITS-1:0] cos_out
);

    localparam int CW    = e2q_pkg::CW;
    localparam int N     = e2q_pkg::CORDIC_ITERS;
    localparam int ASH   = 32 - ANGLE_BITS;
    localparam int FRAC  = COMPONENT_BITS - 2;
    localparam int RSH   = e2q_pkg::FRAC_INT - FRAC;
    localparam logic signed [CW-1:0] RND = (RSH > 0) ? (CW'(1) <<< (RSH - 1)) : '0;
    localparam logic signed [CW-1:0] ONE = CW'(1) <<< FRAC;

    logic signed [CW-1:0] x_reg [0:N];
    logic signed [CW-1:0] y_reg [0:N];
    logic signed [CW-1:0] z_reg [0:N];
    logic                 flip_reg [0:N];
    logic                 v_reg [0:N];

    logic signed [CW-1:0] z_in;
    logic signed [CW-1:0] z_fold;
    logic                 flip_in;

    // half angle in Q2.30, folded into +-pi/2
    always_comb begin
        z_in    = CW'(angle) <<< ASH;
        z_fold  = z_in;
        flip_in = 1'b0;
        if (z_in > e2q_pkg::HALF_PI_Q30) begin
            z_fold  = z_in - e2q_pkg::PI_Q30;
            flip_in = 1'b1;
        end else if (z_in < -e2q_pkg::HALF_PI_Q30) begin
            z_fold  = z_in + e2q_pkg::PI_Q30;
            flip_in = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (ce) begin
            v_reg[0] <= in_valid;
        end
        if (ce) begin
            x_reg[0]    <= e2q_pkg::GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_fold;
            flip_reg[0] <= flip_in;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        localparam logic signed [CW-1:0] ATAN = CW'(e2q_pkg::ATAN_TAB[i]);
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (ce) begin
                v_reg[i+1] <= v_reg[i];
            end
            if (ce) begin
                flip_reg[i+1] <= flip_reg[i];
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
            end
        end
    end

    logic signed [CW-1:0] xf, yf, xr, yr, xc, yc;

    always_comb begin
        xf = flip_reg[N] ? -x_reg[N] : x_reg[N];
        yf = flip_reg[N] ? -y_reg[N] : y_reg[N];
        xr = (xf + RND) >>> RSH;
        yr = (yf + RND) >>> RSH;
        xc = (xr > ONE) ? ONE : ((xr < -ONE) ? -ONE : xr);
        yc = (yr > ONE) ? ONE : ((yr < -ONE) ? -ONE : yr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (ce) begin
            out_valid <= v_reg[N];
        end
        if (ce) begin
            sin_out <= yc[COMPONENT_BITS-1:0];
            cos_out <= xc[COMPONENT_BITS-1:0];
        end
    end

endmodule

// ===== src/e2q_combine.sv =====
// ============================================================================
// e2q_combine
// Three-stage product tree: pair products, triple products, then the
// rounded and saturated quaternion sums.
// ============================================================================
module e2q_combine #(
    parameter int COMPONENT_BITS = e2q_pkg::COMPONENT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             ce,
    input  logic                             in_valid,
    input  logic signed [COMPONENT_BITS-1:0] sy,
    input  logic signed [COMPONENT_BITS-1:0] cy,
    input  logic signed [COMPONENT_BITS-1:0] sp,
    input  logic signed [COMPONENT_BITS-1:0] cp,
    input  logic signed [COMPONENT_BITS-1:0] sr,
    input  logic signed [COMPONENT_BITS-1:0] cr,
    output logic                             out_valid,
    output logic signed [COMPONENT_BITS-1:0] quat_w,
    output logic signed [COMPONENT_BITS-1:0] quat_x,
    output logic signed [COMPONENT_BITS-1:0] quat_y,
    output logic signed [COMPONENT_BITS-1:0] quat_z
);

    localparam int CB   = COMPONENT_BITS;
    localparam int PW   = 2 * CB;
    localparam int SW   = PW + 1;
    localparam int FRAC = CB - 2;
    localparam logic signed [PW-1:0] PRND = PW'(1) <<< (FRAC - 1);
    localparam logic signed [SW-1:0] SRND = SW'(1) <<< (FRAC - 1);
    localparam logic signed [SW-1:0] ONE  = SW'(1) <<< FRAC;

    // stage a: pair products
    logic signed [PW-1:0] cycp_reg, sysp_reg, cysp_reg, sycp_reg;
    logic signed [CB-1:0] sr_a_reg, cr_a_reg;
    logic                 va_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (ce) begin
            va_reg <= in_valid;
        end
        if (ce) begin
            cycp_reg <= cy * cp;
            sysp_reg <= sy * sp;
            cysp_reg <= cy * sp;
            sycp_reg <= sy * cp;
            sr_a_reg <= sr;
            cr_a_reg <= cr;
        end
    end

    // stage b: round pair products, multiply by third factor
    logic signed [PW-1:0] cycp_w, sysp_w, cysp_w, sycp_w;
    logic signed [CB-1:0] cycp_r, sysp_r, cysp_r, sycp_r;

    always_comb begin
        cycp_w = (cycp_reg + PRND) >>> FRAC;
        sysp_w = (sysp_reg + PRND) >>> FRAC;
        cysp_w = (cysp_reg + PRND) >>> FRAC;
        sycp_w = (sycp_reg + PRND) >>> FRAC;
        cycp_r = cycp_w[CB-1:0];
        sysp_r = sysp_w[CB-1:0];
        cysp_r = cysp_w[CB-1:0];
        sycp_r = sycp_w[CB-1:0];
    end

    logic signed [PW-1:0] w1_reg, w2_reg, x1_reg, x2_reg;
    logic signed [PW-1:0] y1_reg, y2_reg, z1_reg, z2_reg;
    logic                 vb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (ce) begin
            vb_reg <= va_reg;
        end
        if (ce) begin
            w1_reg <= cycp_r * cr_a_reg;
            w2_reg <= sysp_r * sr_a_reg;
            x1_reg <= cycp_r * sr_a_reg;
            x2_reg <= sysp_r * cr_a_reg;
            y1_reg <= cysp_r * cr_a_reg;
            y2_reg <= sycp_r * sr_a_reg;
            z1_reg <= sycp_r * cr_a_reg;
            z2_reg <= cysp_r * sr_a_reg;
        end
    end

    // stage c: exact sum, round, saturate
    function automatic logic signed [CB-1:0] round_sat(input logic signed [SW-1:0] t);
        logic signed [SW-1:0] r;
        r = (t + SRND) >>> FRAC;
        if (r > ONE) begin
            r = ONE;
        end else if (r < -ONE) begin
            r = -ONE;
        end
        return r[CB-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (ce) begin
            out_valid <= vb_reg;
        end
        if (ce) begin
            quat_w <= round_sat(SW'(w1_reg) + SW'(w2_reg));
            quat_x <= round_sat(SW'(x1_reg) - SW'(x2_reg));
            quat_y <= round_sat(SW'(y1_reg) + SW'(y2_reg));
            quat_z <= round_sat(SW'(z1_reg) - SW'(z2_reg));
        end
    end

endmodule

// ===== src/euler_to_quaternion.sv =====
// ============================================================================
// euler_to_quaternion
// Z-Y-X Euler angles (yaw, pitch, roll) to a unit quaternion in fixed point.
// ============================================================================
// usage
//   input channel s_*: one item is a yaw, pitch, roll triple in radians,
//   signed Q3.13 at the default width, taken when s_valid and s_ready are high
//   result channel m_*: one item is w, x, y, z in signed Q1.14, rounded and
//   saturated to plus or minus one, taken when m_valid and m_ready are high
//   pipeline: 1 fold stage, 30 cordic iteration stages, 1 sine/cosine
//     rounding stage, 3 product stages (pair products, triple products,
//     sum)
//   throughput: one item per cycle while no result stalls, set by the fully unrolled cordic lanes
//   stall: the whole pipeline holds, bubbles included, while a result waits
//   on m_ready; s_ready drops in the same cycle, so nothing is lost
//   reset: aresetn (synchronous, active low) clears all valid bits; items
//   in flight are dropped, data registers keep whatever they held
//   no state is kept between items
// ============================================================================
module euler_to_quaternion #(
    parameter int ANGLE_BITS     = e2q_pkg::ANGLE_BITS_DEF,
    parameter int COMPONENT_BITS = e2q_pkg::COMPONENT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [ANGLE_BITS-1:0]     s_yaw_angle,
    input  logic signed [ANGLE_BITS-1:0]     s_pitch_angle,
    input  logic signed [ANGLE_BITS-1:0]     s_roll_angle,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [COMPONENT_BITS-1:0] m_quat_w,
    output logic signed [COMPONENT_BITS-1:0] m_quat_x,
    output logic signed [COMPONENT_BITS-1:0] m_quat_y,
    output logic signed [COMPONENT_BITS-1:0] m_quat_z
);

    localparam int FRAC = COMPONENT_BITS - 2;
    localparam logic signed [COMPONENT_BITS-1:0] ONE = COMPONENT_BITS'(1) <<< FRAC;

    // global advance: move whenever the output slot is free or being taken
    logic ce;
    assign ce      = m_ready || !m_valid;
    assign s_ready = ce;

    logic                             vy, vp, vr;
    logic signed [COMPONENT_BITS-1:0] sy, cy, sp, cp, sr, cr;

    // three identical half-angle sine/cosine lanes
    e2q_cordic #(
        .ANGLE_BITS     (ANGLE_BITS),
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_yaw (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_valid),
        .angle     (s_yaw_angle),
        .out_valid (vy),
        .sin_out   (sy),
        .cos_out   (cy)
    );

    e2q_cordic #(
        .ANGLE_BITS     (ANGLE_BITS),
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_pitch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_valid),
        .angle     (s_pitch_angle),
        .out_valid (vp),
        .sin_out   (sp),
        .cos_out   (cp)
    );

    e2q_cordic #(
        .ANGLE_BITS     (ANGLE_BITS),
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_roll (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_valid),
        .angle     (s_roll_angle),
        .out_valid (vr),
        .sin_out   (sr),
        .cos_out   (cr)
    );

    // product tree; its last stage is the output register
    e2q_combine #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_combine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (vy),
        .sy        (sy),
        .cy        (cy),
        .sp        (sp),
        .cp        (cp),
        .sr        (sr),
        .cr        (cr),
        .out_valid (m_valid),
        .quat_w    (m_quat_w),
        .quat_x    (m_quat_x),
        .quat_y    (m_quat_y),
        .quat_z    (m_quat_z)
    );

    // lanes run in lockstep
    a_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (vy == vp) && (vy == vr))
        else $error("cordic lanes out of step");

    // w and x results stay within plus or minus one
    a_w_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_quat_w <= ONE) && (m_quat_w >= -ONE)
                 && (m_quat_x <= ONE) && (m_quat_x >= -ONE))
        else $error("quaternion component out of range");

    // input only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without output stall");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for euler_to_quaternion: a directed angle table, then
// random triples, with random idling on both sides and one long result stall.
// Each result is checked against a bit-true CORDIC predictor or a chk row.
// ============================================================================
module tb;

    localparam int AB   = e2q_pkg::ANGLE_BITS_DEF;
    localparam int CB   = e2q_pkg::COMPONENT_BITS_DEF;
    localparam int FRAC = CB - 2;
    localparam int ITER = e2q_pkg::CORDIC_ITERS;
    localparam int NUM_RANDOM = 800;
    localparam int LATENCY    = 35;
    localparam longint CYCLE_LIMIT = 400000;

    // one row of the directed table; chk set where the quaternion is obvious
    typedef struct {
        logic signed [AB-1:0] yaw;
        logic signed [AB-1:0] pitch;
        logic signed [AB-1:0] roll;
        bit                   chk;
        logic signed [CB-1:0] w, x, y, z;
    } angle_row_t;

    typedef struct {
        logic signed [CB-1:0] w, x, y, z;
    } quat_t;

    localparam logic signed [CB-1:0] ONE  = CB'(1) <<< FRAC;
    localparam logic signed [CB-1:0] ZERO = '0;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic signed [AB-1:0] s_yaw_angle, s_pitch_angle, s_roll_angle;
    logic m_valid;
    logic m_ready;
    logic signed [CB-1:0] m_quat_w, m_quat_x, m_quat_y, m_quat_z;

    quat_t  quat_queue[$];
    longint atan_q30[ITER];
    int     mismatch_count;
    longint cycle_count;
    bit     calm_phase;    // last part of the run: no idling
    bit     long_hold;     // receiver held off for a long stretch
    bit     stim_done;

    angle_row_t angle_table[$];

    euler_to_quaternion i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_yaw_angle   (s_yaw_angle),
        .s_pitch_angle (s_pitch_angle),
        .s_roll_angle  (s_roll_angle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_quat_w      (m_quat_w),
        .m_quat_x      (m_quat_x),
        .m_quat_y      (m_quat_y),
        .m_quat_z      (m_quat_z)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // floor shift, the same as an arithmetic right shift of a signed value
    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rshift(longint v, int s);
        if (s <= 0) begin
            return v;
        end
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_unit(longint v);
        longint one;
        one = longint'(1) <<< FRAC;
        if (v > one) begin
            return one;
        end
        if (v < -one) begin
            return -one;
        end
        return v;
    endfunction

    // atan(2^-i) in q30 from its taylor series summed in q60; i = 0 is a constant
    function automatic longint atan_term(int i);
        longint acc;
        longint term;
        int k;
        acc = 0;
        if (i == 0) begin
            return 64'sd843314857;
        end
        for (k = 0; i * (2 * k + 1) <= 60; k++) begin
            term = (longint'(1) <<< (60 - i * (2 * k + 1))) / longint'(2 * k + 1);
            acc = (k % 2 == 1) ? acc - term : acc + term;
        end
        return (acc + (longint'(1) <<< 29)) >>> 30;
    endfunction

    // sine and cosine of half the angle, q1.FRAC
    task automatic half_angle_sincos(input logic signed [AB-1:0] ang,
                                     output longint s, output longint c);
        longint zr, xr, yr, dx, dy;
        bit flip;
        zr = longint'(ang) * (longint'(1) <<< (32 - AB));
        xr = 64'sd652032874;
        yr = 0;
        flip = 1'b0;
        // fold into [-pi/2, pi/2], negate both outputs afterwards
        if (zr > 64'sd1686629713) begin
            zr -= 64'sd3373259426;
            flip = 1'b1;
        end else if (zr < -64'sd1686629713) begin
            zr += 64'sd3373259426;
            flip = 1'b1;
        end
        for (int i = 0; i < ITER; i++) begin
            dx = fshift(yr, i);
            dy = fshift(xr, i);
            if (zr >= 0) begin
                xr -= dx; yr += dy; zr -= atan_q30[i];
            end else begin
                xr += dx; yr -= dy; zr += atan_q30[i];
            end
        end
        if (flip) begin
            xr = -xr;
            yr = -yr;
        end
        s = clamp_unit(rshift(yr, 30 - FRAC));
        c = clamp_unit(rshift(xr, 30 - FRAC));
    endtask

    function automatic longint mix(longint p1, longint f1, longint p2, longint f2,
                                   bit sub);
        longint t;
        t = sub ? p1 * f1 - p2 * f2 : p1 * f1 + p2 * f2;
        return clamp_unit(rshift(t, FRAC));
    endfunction

    task automatic predict_quat(input logic signed [AB-1:0] yaw, pitch, roll,
                                output quat_t q);
        longint sy, cy, sp, cp, sr, cr, cycp, sysp, cysp, sycp;
        half_angle_sincos(yaw, sy, cy);
        half_angle_sincos(pitch, sp, cp);
        half_angle_sincos(roll, sr, cr);
        cycp = rshift(cy * cp, FRAC);
        sysp = rshift(sy * sp, FRAC);
        cysp = rshift(cy * sp, FRAC);
        sycp = rshift(sy * cp, FRAC);
        q.w = CB'(mix(cycp, cr, sysp, sr, 1'b0));
        q.x = CB'(mix(cycp, sr, sysp, cr, 1'b1));
        q.y = CB'(mix(cysp, cr, sycp, sr, 1'b0));
        q.z = CB'(mix(sycp, cr, cysp, sr, 1'b1));
    endtask

    function automatic angle_row_t row(int yaw, int pitch, int roll);
        angle_row_t r;
        r.yaw = AB'(yaw); r.pitch = AB'(pitch); r.roll = AB'(roll);
        r.chk = 1'b0;
        r.w = '0; r.x = '0; r.y = '0; r.z = '0;
        return r;
    endfunction

    // weighted angle: extremes, fold edges near +-pi, small angles near zero, or anything
    function automatic logic signed [AB-1:0] pick_angle();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: begin
                return ($urandom_range(0, 1) == 1) ? AB'(32767) : AB'(-32768);
            end
            1: begin
                // around +-pi in q3.13 (25736), where the half angle folds
                return AB'(($urandom_range(0, 1) ? 25736 : -25736)
                           + $signed($urandom_range(0, 8)) - 4);
            end
            2: begin
                return AB'($signed($urandom_range(0, 64)) - 32);
            end
            default: begin
                return AB'($urandom);
            end
        endcase
    endfunction

    task automatic send_item(input logic signed [AB-1:0] yaw, pitch, roll);
        s_valid       <= 1'b1;
        s_yaw_angle   <= yaw;
        s_pitch_angle <= pitch;
        s_roll_angle  <= roll;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic sender_gap();
        int n;
        if (!calm_phase && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    // stimulus
    initial begin
        quat_t q;
        angle_row_t r;
        int n_rand;
        for (int i = 0; i < ITER; i++) begin
            atan_q30[i] = atan_term(i);
        end
        calm_phase = 1'b0;
        stim_done = 1'b0;
        s_valid = 1'b0;
        s_yaw_angle = '0;
        s_pitch_angle = '0;
        s_roll_angle = '0;
        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table: zero angles give the identity quaternion
        r = row(0, 0, 0);
        r.chk = 1'b1; r.w = ONE; r.x = ZERO; r.y = ZERO; r.z = ZERO;
        angle_table.push_back(r);
        angle_table.push_back(row(32767, 32767, 32767));
        angle_table.push_back(row(-32768, -32768, -32768));
        angle_table.push_back(row(32767, 0, 0));
        angle_table.push_back(row(0, -32768, 0));
        angle_table.push_back(row(0, 0, 32767));
        angle_table.push_back(row(25736, 0, 0));      // near pi: fold edge
        angle_table.push_back(row(25737, 25737, 25737));
        angle_table.push_back(row(-25736, -25737, -25735));
        angle_table.push_back(row(12868, 0, 0));      // pi/2 yaw
        angle_table.push_back(row(0, 12868, 0));      // pi/2 pitch
        angle_table.push_back(row(0, 0, -12868));     // -pi/2 roll
        angle_table.push_back(row(1, -1, 1));
        angle_table.push_back(row(-1, -1, -1));
        angle_table.push_back(row(16'h5555, 16'hAAAA, 16'h5555));
        angle_table.push_back(row(16'hAAAA, 16'h5555, 16'hAAAA));
        angle_table.push_back(row(6434, 12868, 19302));
        angle_table.push_back(row(-19302, 6434, -12868));
        foreach (angle_table[i]) begin
            r = angle_table[i];
            if (r.chk) begin
                q.w = r.w; q.x = r.x; q.y = r.y; q.z = r.z;
            end else begin
                predict_quat(r.yaw, r.pitch, r.roll, q);
            end
            quat_queue.push_back(q);
            send_item(r.yaw, r.pitch, r.roll);
            sender_gap();
        end

        // random part; the tail runs without idling
        n_rand = NUM_RANDOM - angle_table.size();
        for (int i = 0; i < n_rand; i++) begin
            logic signed [AB-1:0] ya, pa, ra;
            if (i > n_rand - 100) begin
                calm_phase = 1'b1;
            end
            ya = pick_angle();
            pa = pick_angle();
            ra = pick_angle();
            predict_quat(ya, pa, ra, q);
            quat_queue.push_back(q);
            send_item(ya, pa, ra);
            sender_gap();
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random bursts of back-pressure plus one long hold-off
    initial begin
        int n;
        m_ready = 1'b0;
        long_hold = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!long_hold && quat_queue.size() > 0 && cycle_count > 300) begin
                // fill the pipe and stall the input
                long_hold = 1'b1;
                m_ready <= 1'b0;
                repeat (200) @(negedge aclk);
            end
            if (!calm_phase && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 15);
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // result checking at the rising edge
    always @(posedge aclk) begin
        quat_t q;
        if (aresetn && m_valid && m_ready) begin
            if (quat_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected item w=%0d x=%0d y=%0d z=%0d",
                             m_quat_w, m_quat_x, m_quat_y, m_quat_z);
                end
            end else begin
                q = quat_queue.pop_front();
                if (m_quat_w !== q.w || m_quat_x !== q.x
                    || m_quat_y !== q.y || m_quat_z !== q.z) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("exp w=%0d x=%0d y=%0d z=%0d got %0d %0d %0d %0d",
                                 q.w, q.x, q.y, q.z,
                                 m_quat_w, m_quat_x, m_quat_y, m_quat_z);
                    end
                end
            end
        end
    end

    // end of run and timeout
    initial begin
        cycle_count = 0;
        mismatch_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
            if (stim_done && quat_queue.size() == 0) begin
                repeat (LATENCY + 10) @(posedge aclk);
                if (mismatch_count == 0) begin
                    $display("tb: clean");
                end else begin
                    $display("tb: errors");
                end
                $finish;
            end
        end
    end

endmodule
